// ===== rtl/mspfr_pkg.sv =====
// Shared types and constants for the MSP v1 frame receiver.
// No dependencies; imported by every module of the receiver.
package mspfr_pkg;

   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_M      = 8'h4D;
   localparam logic [7:0] CH_GT     = 8'h3E;

   localparam logic [2:0] PH_HUNT = 3'd0;
   localparam logic [2:0] PH_M    = 3'd1;
   localparam logic [2:0] PH_GT   = 3'd2;
   localparam logic [2:0] PH_SIZE = 3'd3;
   localparam logic [2:0] PH_CMD  = 3'd4;
   localparam logic [2:0] PH_DATA = 3'd5;
   localparam logic [2:0] PH_CSUM = 3'd6;

   localparam logic [2:0] K_DATA    = 3'd0;
   localparam logic [2:0] K_GOOD    = 3'd1;
   localparam logic [2:0] K_BADSUM  = 3'd2;
   localparam logic [2:0] K_HDR_TO  = 3'd3;
   localparam logic [2:0] K_BODY_TO = 3'd4;

   localparam logic       OP_BYTE = 1'b0;
   localparam logic       OP_TICK = 1'b1;

   localparam logic [1:0] REG_HDR_TIMEOUT = 2'd0;
   localparam logic [1:0] REG_BYTE_GAP    = 2'd1;
   localparam logic [1:0] REG_MAX_PAYLOAD = 2'd2;

   localparam logic [15:0] HDR_TIMEOUT_RESET = 16'd1000;
   localparam logic [15:0] BYTE_GAP_RESET    = 16'd500;
   localparam logic [7:0]  MAX_PAYLOAD_RESET = 8'd64;

   typedef struct packed {
      logic [15:0] hdr_timeout;
      logic [15:0] byte_gap;
      logic [7:0]  max_payload;
   } csr_type;

   typedef struct packed {
      logic [7:0] frame_size;
      logic [7:0] frame_cmd;
      logic [7:0] byte_index;
      logic [7:0] data_byte;
      logic [2:0] kind;
   } result_type;

endpackage

// ===== rtl/mspfr_parser.sv =====
// Frame parser: phase, checksum, counters and the per-word next-state logic.
// Depends on mspfr_pkg.
module mspfr_parser
   import mspfr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic       op,
   input  logic [7:0] rx_byte,
   input  csr_type    csr,
   output logic       res_valid,
   output result_type res
);

   logic [2:0]  phase_ff, phase_in;
   logic [7:0]  size_ff, size_in;
   logic [7:0]  cmd_ff, cmd_in;
   logic [7:0]  xor_ff, xor_in;
   logic [7:0]  count_ff, count_in;
   logic [15:0] tick_ff, tick_in;
   logic        hunting;
   logic [15:0] limit;
   logic [7:0]  count_inc;

   always_comb begin
      phase_in  = phase_ff;
      size_in   = size_ff;
      cmd_in    = cmd_ff;
      xor_in    = xor_ff;
      count_in  = count_ff;
      tick_in   = tick_ff;
      res_valid = 1'b0;
      res       = '0;
      hunting   = (phase_ff == PH_HUNT) || (phase_ff == PH_M) || (phase_ff == PH_GT);
      limit     = hunting ? csr.hdr_timeout : csr.byte_gap;
      count_inc = count_ff + 8'd1;
      if (step && op == OP_TICK) begin
         if (tick_ff >= limit) begin
            res_valid = 1'b1;
            if (hunting) begin
               res.kind = K_HDR_TO;
            end else begin
               res.kind       = K_BODY_TO;
               res.frame_cmd  = cmd_ff;
               res.frame_size = size_ff;
            end
            phase_in = PH_HUNT;
            tick_in  = '0;
         end else begin
            tick_in = tick_ff + 16'd1;
         end
      end else if (step) begin
         case (phase_ff)
            PH_HUNT: begin
               if (rx_byte == CH_DOLLAR) begin
                  phase_in = PH_M;
               end
            end
            PH_M: begin
               if (rx_byte == CH_M) begin
                  phase_in = PH_GT;
               end else if (rx_byte != CH_DOLLAR) begin
                  phase_in = PH_HUNT;
               end
            end
            PH_GT: begin
               if (rx_byte == CH_GT) begin
                  phase_in = PH_SIZE;
                  tick_in  = '0;
                  size_in  = '0;
                  cmd_in   = '0;
                  xor_in   = '0;
                  count_in = '0;
               end else if (rx_byte == CH_DOLLAR) begin
                  phase_in = PH_M;
               end else begin
                  phase_in = PH_HUNT;
               end
            end
            PH_SIZE: begin
               tick_in  = '0;
               size_in  = rx_byte;
               xor_in   = rx_byte;
               phase_in = PH_CMD;
            end
            PH_CMD: begin
               tick_in  = '0;
               cmd_in   = rx_byte;
               xor_in   = xor_ff ^ rx_byte;
               count_in = '0;
               phase_in = (size_ff == 8'd0) ? PH_CSUM : PH_DATA;
            end
            PH_DATA: begin
               tick_in = '0;
               xor_in  = xor_ff ^ rx_byte;
               if (count_ff < csr.max_payload) begin
                  res_valid      = 1'b1;
                  res.kind       = K_DATA;
                  res.data_byte  = rx_byte;
                  res.byte_index = count_ff;
                  res.frame_cmd  = cmd_ff;
                  res.frame_size = size_ff;
               end
               count_in = count_inc;
               if (count_inc >= size_ff) begin
                  phase_in = PH_CSUM;
               end
            end
            PH_CSUM: begin
               res_valid      = 1'b1;
               res.kind       = (rx_byte == xor_ff) ? K_GOOD : K_BADSUM;
               res.frame_cmd  = cmd_ff;
               res.frame_size = size_ff;
               phase_in       = PH_HUNT;
               tick_in        = '0;
            end
            default: begin
               phase_in = PH_HUNT;
               tick_in  = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         size_ff  <= '0;
         cmd_ff   <= '0;
         xor_ff   <= '0;
         count_ff <= '0;
         tick_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         size_ff  <= size_in;
         cmd_ff   <= cmd_in;
         xor_ff   <= xor_in;
         count_ff <= count_in;
         tick_ff  <= tick_in;
      end
   end

endmodule

// ===== rtl/msp_v1_frame_receiver.sv =====
// MSP v1 response frame receiver, top level: input register, control registers,
// parser and result register. Depends on mspfr_pkg and mspfr_parser.
//
// Each input word is one received serial byte (req_tuser = 0) or one timer tick
// (req_tuser = 1). The block deframes "$ M >" size cmd payload checksum frames
// and yields at most one result word per input word: a payload byte with its
// index, frame good or checksum error, or a header or body timeout. One input
// word is taken every clock cycle unless rsp_tready holds the output; a word
// passes through the input register, the parser logic and the result register.
// The input register also absorbs one word while a result waits on rsp_tready.
// The user must write control registers through csr_ only while idle; the block does not enforce it.
module msp_v1_frame_receiver
   import mspfr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  logic        req_tuser,   // [0] op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [7:0] data_byte, [15:8] byte_index,
                                    // [23:16] frame_cmd, [31:24] frame_size
   output logic [2:0]  rsp_tuser,   // [2:0] kind
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   csr_type    csr_ff;
   logic       in_valid_ff;
   logic       in_op_ff;
   logic [7:0] in_byte_ff;
   logic       out_valid_ff;
   result_type out_ff;
   logic       advance;
   logic       step;
   logic       res_valid;
   result_type res;

   assign advance    = !out_valid_ff || rsp_tready;
   assign step       = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;

   mspfr_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .op        (in_op_ff),
      .rx_byte   (in_byte_ff),
      .csr       (csr_ff),
      .res_valid (res_valid),
      .res       (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.hdr_timeout <= HDR_TIMEOUT_RESET;
         csr_ff.byte_gap    <= BYTE_GAP_RESET;
         csr_ff.max_payload <= MAX_PAYLOAD_RESET;
      end else if (csr_we) begin
         case (csr_index)
            REG_HDR_TIMEOUT: csr_ff.hdr_timeout <= csr_wdata;
            REG_BYTE_GAP:    csr_ff.byte_gap    <= csr_wdata;
            REG_MAX_PAYLOAD: csr_ff.max_payload <= csr_wdata[7:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (advance) begin
            out_valid_ff <= step && res_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_op_ff   <= req_tuser;
         in_byte_ff <= req_tdata;
      end
      if (step && res_valid) begin
         out_ff <= res;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ff.kind;
   assign rsp_tdata  = {out_ff.frame_size, out_ff.frame_cmd, out_ff.byte_index,
                        out_ff.data_byte};

endmodule
